>>> sv/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// Shared types and constants of the bitmap text renderer: item layouts, codes,
// controller command and datapath status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package btf_pkg;

  localparam int unsigned FRAME_PIXELS_WIDE_DEF = 240;
  localparam int unsigned SCREEN_WIDE_DEF       = 240;
  localparam int unsigned SCREEN_HIGH_DEF       = 320;
  localparam int unsigned FONT_WORDS_DEF        = 4096;

  // wide enough for any glyph row address and any font index
  localparam int unsigned FONT_ADDR_W = 15;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [6:0] CHAR_FIRST = 7'd32;
  localparam logic [6:0] CHAR_DEL   = 7'd127;
  localparam logic [4:0] GLYPH_W_RST = 5'd11;
  localparam logic [5:0] GLYPH_H_RST = 6'd18;
  localparam logic [4:0] GLYPH_W_MAX = 5'd16;
  localparam logic [5:0] GLYPH_H_MAX = 6'd32;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DRAW  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_WIDTH  = 2'd0,
    CFG_GLYPH_HEIGHT = 2'd1,
    CFG_FG_COLOR     = 2'd2,
    CFG_BG_COLOR     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWS
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  start_x;
    logic [8:0]  start_y;
    logic [11:0] font_index;
    logic [15:0] font_word;
    logic [6:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [16:0] row_address;
    logic [15:0] row_bits;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic load_font;
    logic start_string;
    logic place_char;
    logic setup;
    logic issue_row;
  } ctrl_cmd_t;

  typedef struct packed {
    logic draws;
    logic slot_free;
    logic final_row;
  } dp_status_t;

endpackage

`default_nettype wire

>>> sv/btf_stream_if.sv
// ----------------------------------------------------------------------------
// btf_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface btf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/btf_ram.sv
// ----------------------------------------------------------------------------
// btf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/btf_ctrl.sv
// ----------------------------------------------------------------------------
// btf_ctrl
// Sequencer: decodes accepted items and steps a character through setup and
// one font read per glyph row.
// ----------------------------------------------------------------------------
`default_nettype none

module btf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          in_kind_i,
  output logic                     in_ready_o,
  input  wire btf_pkg::dp_status_t status_i,
  output btf_pkg::ctrl_cmd_t       cmd_o
);
  import btf_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (accept) begin
          unique case (in_kind_i)
            KIND_LOAD:  cmd_o.load_font    = 1'b1;
            KIND_START: cmd_o.start_string = 1'b1;
            KIND_DRAW: begin
              cmd_o.place_char = 1'b1;
              if (status_i.draws) begin
                state_d = ST_SETUP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_ROWS;
      end
      ST_ROWS: begin
        if (status_i.slot_free) begin
          cmd_o.issue_row = 1'b1;
          if (status_i.final_row) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/btf_dpath.sv
// ----------------------------------------------------------------------------
// btf_dpath
// Datapath: glyph size registers, text cursor, font memory, row address
// generation and a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module btf_dpath #(
  parameter int unsigned FRAME_PIXELS_WIDE = btf_pkg::FRAME_PIXELS_WIDE_DEF,
  parameter int unsigned SCREEN_WIDE       = btf_pkg::SCREEN_WIDE_DEF,
  parameter int unsigned SCREEN_HIGH       = btf_pkg::SCREEN_HIGH_DEF,
  parameter int unsigned FONT_WORDS        = btf_pkg::FONT_WORDS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [btf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [btf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire btf_pkg::in_item_t                in_data_i,
  input  wire btf_pkg::ctrl_cmd_t               cmd_i,
  output btf_pkg::dp_status_t                   status_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output btf_pkg::out_item_t                    out_data_o
);
  import btf_pkg::*;

  localparam int unsigned RamAw  = $clog2(FONT_WORDS);
  localparam int unsigned AccRaw = $clog2(1055 * FRAME_PIXELS_WIDE + 256);
  localparam int unsigned AccW   = (AccRaw > 17) ? AccRaw : 17;
  localparam int unsigned FullLim = FRAME_PIXELS_WIDE * SCREEN_HIGH - 1;
  localparam int unsigned AddrLim = (FullLim > 131071) ? 131071 : FullLim;

  logic [4:0]  gw_q;
  logic [5:0]  gh_q;
  logic [4:0]  w_eff;
  logic [5:0]  h_eff;

  logic [7:0]  col_q;
  logic [9:0]  row_q;
  logic        stopped_q;
  logic [6:0]  code_q;
  logic [FONT_ADDR_W-1:0] glyph_q;
  logic [AccW-1:0]        run_q;
  logic [4:0]  r_q;

  logic [10:0] col_sum;
  logic [9:0]  row_wrap;
  logic [10:0] row_chk;
  logic        wrap;
  logic        stop;
  logic        code_ok;

  logic [FONT_ADDR_W-1:0] load_idx;
  logic        load_hit;
  logic        rd_hit;
  logic        ram_we;
  logic [RamAw-1:0] ram_addr;
  logic [15:0] ram_rdata;
  logic [16:0] sat_addr;

  logic        pend_q;
  logic        pend_hit_q;
  logic        pend_last_q;
  logic [16:0] pend_addr_q;

  out_item_t   queue_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        pop;
  logic [2:0]  level;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GLYPH_W_RST;
      gh_q <= GLYPH_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GLYPH_WIDTH:  gw_q <= cfg_data_i[4:0];
        CFG_GLYPH_HEIGHT: gh_q <= cfg_data_i[5:0];
        CFG_FG_COLOR, CFG_BG_COLOR: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (gw_q == '0) begin
      w_eff = 5'd1;
    end else if (gw_q > GLYPH_W_MAX) begin
      w_eff = GLYPH_W_MAX;
    end else begin
      w_eff = gw_q;
    end
    if (gh_q == '0) begin
      h_eff = 6'd1;
    end else if (gh_q > GLYPH_H_MAX) begin
      h_eff = GLYPH_H_MAX;
    end else begin
      h_eff = gh_q;
    end
  end

  // cursor placement of an incoming character
  assign code_ok  = (in_data_i.char_code >= CHAR_FIRST) && (in_data_i.char_code != CHAR_DEL);
  assign col_sum  = 11'(col_q) + 11'(w_eff);
  assign wrap     = col_sum >= 11'(SCREEN_WIDE);
  assign row_wrap = row_q + 10'(h_eff);
  assign row_chk  = 11'(row_wrap) + 11'(h_eff);
  assign stop     = wrap && (row_chk >= 11'(SCREEN_HIGH));

  assign status_o.draws = !stopped_q && code_ok && !stop
                          && !(wrap && (in_data_i.char_code == CHAR_FIRST));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      stopped_q <= 1'b0;
    end else if (cmd_i.start_string) begin
      col_q     <= in_data_i.start_x;
      row_q     <= 10'(in_data_i.start_y);
      stopped_q <= 1'b0;
    end else if (cmd_i.place_char) begin
      if (!stopped_q && code_ok && wrap) begin
        col_q <= '0;
        row_q <= row_wrap;
        if (stop) begin
          stopped_q <= 1'b1;
        end
      end
    end else if (cmd_i.setup) begin
      col_q <= 8'(col_sum);
    end
  end

  // row sequencing
  always_ff @(posedge clk_i) begin
    if (cmd_i.place_char) begin
      code_q <= in_data_i.char_code;
    end
    if (cmd_i.setup) begin
      glyph_q <= FONT_ADDR_W'(code_q - CHAR_FIRST) * FONT_ADDR_W'(h_eff);
      run_q   <= AccW'(row_q) * AccW'(FRAME_PIXELS_WIDE) + AccW'(col_q);
      r_q     <= '0;
    end else if (cmd_i.issue_row) begin
      glyph_q <= glyph_q + FONT_ADDR_W'(1);
      run_q   <= run_q + AccW'(FRAME_PIXELS_WIDE);
      r_q     <= r_q + 5'd1;
    end
  end

  assign status_o.final_row = (6'(r_q) + 6'd1) == h_eff;

  // font memory
  assign load_idx = FONT_ADDR_W'(in_data_i.font_index);
  assign load_hit = load_idx < FONT_ADDR_W'(FONT_WORDS);
  assign rd_hit   = glyph_q < FONT_ADDR_W'(FONT_WORDS);
  assign ram_we   = cmd_i.load_font && load_hit;
  assign ram_addr = cmd_i.issue_row ? glyph_q[RamAw-1:0] : load_idx[RamAw-1:0];

  btf_ram #(
    .WIDTH (16),
    .DEPTH (FONT_WORDS)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.font_word),
    .rdata_o (ram_rdata)
  );

  assign sat_addr = (run_q > AccW'(AddrLim)) ? 17'(AddrLim) : run_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.issue_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_row) begin
      pend_hit_q  <= rd_hit;
      pend_last_q <= status_o.final_row;
      pend_addr_q <= sat_addr;
    end
  end

  // result queue
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = queue_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign level       = 3'(cnt_q) + 3'(pend_q) - 3'(pop);
  assign status_o.slot_free = level < 3'd2;

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      queue_q[wr_ptr_q] <= '{row_address: pend_addr_q,
                             row_bits:    pend_hit_q ? ram_rdata : 16'd0,
                             last_row:    pend_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (pend_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(pend_q) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

>>> sv/bitmap_text_to_framebuffer.sv
// ----------------------------------------------------------------------------
// bitmap_text_to_framebuffer
// Bitmap font text renderer: loads a font memory, keeps a text cursor and
// emits one framebuffer row address and glyph row per character row.
//
//   channel    dir  payload                                        role
//   item_i     in   kind, start_x, start_y, font_index, font_word,  commands
//                   char_code
//   result_o   out  row_address, row_bits, last_row                 glyph rows
//   cfg_*      in   cfg_idx_i, cfg_data_i (cfg_we_i strobe)         size regs
//
// Load, start and ignored items are accepted directly in the idle state. A drawn
// character steps through cursor placement, the start address multiply in setup,
// then one font memory read per row through the single RAM port.
// The two-entry result queue lets the next item in while rows still wait, and
// row reads pause while the queue is full. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_to_framebuffer #(
  parameter int unsigned FRAME_PIXELS_WIDE = btf_pkg::FRAME_PIXELS_WIDE_DEF,
  parameter int unsigned SCREEN_WIDE       = btf_pkg::SCREEN_WIDE_DEF,
  parameter int unsigned SCREEN_HIGH       = btf_pkg::SCREEN_HIGH_DEF,
  parameter int unsigned FONT_WORDS        = btf_pkg::FONT_WORDS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  btf_stream_if.sink                          item_i,
  btf_stream_if.source                        result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [btf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [btf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import btf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  in_item_t   in_data;
  out_item_t  out_data;
  logic       in_ready;
  logic       out_valid;

  assign in_data       = item_i.data;
  assign item_i.ready  = in_ready;
  assign result_o.valid = out_valid;
  assign result_o.data  = out_data;

  btf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_kind_i  (in_data.kind),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  btf_dpath #(
    .FRAME_PIXELS_WIDE (FRAME_PIXELS_WIDE),
    .SCREEN_WIDE       (SCREEN_WIDE),
    .SCREEN_HIGH       (SCREEN_HIGH),
    .FONT_WORDS        (FONT_WORDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (out_data)
  );

  // row reads only go out with room in the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue_row |-> status.slot_free)
    else $error("row read issued with full result queue");

  // no new item while a character is being set up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.setup |=> !in_ready)
    else $error("input accepted during character rows");

  // the final row read hands control back to the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.issue_row && status.final_row) |=> in_ready)
    else $error("controller stuck after final row");

  // a character only starts rows after being placed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.setup |-> $past(cmd.place_char))
    else $error("setup without a placed character");

endmodule

`default_nettype wire
